[design/rzs_pkg.sv]
// Package of shared constants and types for the rolling z-score signal engine.
package rzs_pkg;
  localparam int WindowLen  = 64;
  localparam int NumSymbols = 64;
  localparam int PriceBits  = 24;
  localparam int SymW   = 6;
  localparam int HeadW  = $clog2(WindowLen);
  localparam int CntW   = $clog2(WindowLen + 1);
  localparam int SampW  = PriceBits + 1;
  localparam int SumW   = SampW + HeadW;
  localparam int SqW    = 2 * SampW + HeadW;
  localparam int PosW   = 32;
  localparam int RingAw = SymW + HeadW;
  localparam logic [31:0] PosMax = 32'h7FFF_FFFF;

  localparam logic OpTick = 1'b0;
  localparam logic OpFill = 1'b1;

  typedef enum logic [0:0] {
    RegEntry = 1'b0,
    RegExit  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [SqW-1:0]  sq;
    logic [CntW-1:0] cnt;
    logic [HeadW-1:0] head;
    logic signed [PosW-1:0] pos;
  } sym_state_t;
endpackage

[design/rolling_zscore_signal_engine_top.sv]
// An order item follows its tick through stages s1, s2 and write-back, then eval registers v1, v2 and the output.
// Throughput is one item each cycle while the output is not stalled; per-symbol state is read, updated and written back
// over two stages, with forwarding from the update and write-back stages.
// The whole pipeline holds while a result waits with the output stalled.
// Reset clears per-symbol valid bits, pipeline valids and the thresholds
// (entry 16, exit 1); the price ring is not reset, and each ring entry is written before its value is used.
module rolling_zscore_signal_engine_top (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic op_i,
  input  logic [5:0] symbol_index_i,
  input  logic [23:0] bid_price_i,
  input  logic [23:0] ask_price_i,
  input  logic fill_side_i,
  input  logic [15:0] fill_quantity_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic order_side_o,
  output logic [23:0] order_price_o,
  output logic [30:0] order_quantity_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import rzs_pkg::*;
  logic en, acc;
  logic [7:0] entry_q, exit_q;
  logic s1_v_q, s1_op_q, s1_fs_q;
  logic [SymW-1:0] s1_sym_q;
  logic [PriceBits-1:0] s1_bid_q, s1_ask_q;
  logic [15:0] s1_fq_q;
  logic [SampW-1:0] s1_samp_q;
  logic s2_v_q, s2_op_q, s2_fs_q;
  logic [SymW-1:0] s2_sym_q;
  logic [PriceBits-1:0] s2_bid_q, s2_ask_q;
  logic [15:0] s2_fq_q;
  logic [SampW-1:0] s2_samp_q;
  sym_state_t s2_st_q;
  sym_state_t rd_st, cur, nst;
  logic wb_v_q, wb_ev_q;
  logic [SymW-1:0] wb_sym_q;
  sym_state_t wb_st_q;
  logic [SampW-1:0] wb_samp_q;
  logic [PriceBits-1:0] wb_bid_q, wb_ask_q;
  logic [SampW-1:0] old;
  logic ev_v;
  logic [SampW-1:0] s0_samp;
  logic signed [PosW+1:0] pn;
  logic [2*SampW-1:0] sqs, sqo;

  assign en = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign acc = in_valid_i && en;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'(exit_q) : 32'(entry_q);
  assign s0_samp = SampW'(bid_price_i) + SampW'(ask_price_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= 8'd16;
      exit_q <= 8'd1;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        RegEntry: entry_q <= pwdata[7:0];
        RegExit:  exit_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      wb_v_q <= 1'b0;
      wb_ev_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= acc;
      s2_v_q <= s1_v_q;
      wb_v_q <= s2_v_q;
      wb_ev_q <= ev_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= op_i;
      s1_sym_q <= symbol_index_i;
      s1_bid_q <= bid_price_i;
      s1_ask_q <= ask_price_i;
      s1_fs_q <= fill_side_i;
      s1_fq_q <= fill_quantity_i;
      s1_samp_q <= s0_samp;
      s2_op_q <= s1_op_q;
      s2_sym_q <= s1_sym_q;
      s2_bid_q <= s1_bid_q;
      s2_ask_q <= s1_ask_q;
      s2_fs_q <= s1_fs_q;
      s2_fq_q <= s1_fq_q;
      s2_samp_q <= s1_samp_q;
      s2_st_q <= cur;
      wb_sym_q <= s2_sym_q;
      wb_st_q <= nst;
      wb_samp_q <= s2_samp_q;
      wb_bid_q <= s2_bid_q;
      wb_ask_q <= s2_ask_q;
    end
  end

  rzs_state_mem u_mem (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .rd_sym_i(symbol_index_i), .rd_state_o(rd_st),
    .wr_en_i(s2_v_q), .wr_sym_i(s2_sym_q), .wr_state_i(nst),
    .ring_addr_i({s1_sym_q, cur.head}),
    .ring_we_i(s1_v_q && s1_op_q == OpTick),
    .ring_wdata_i(s1_samp_q),
    .ring_rdata_o(old)
  );

  always_comb begin
    cur = rd_st;
    if (s2_v_q && s2_sym_q == s1_sym_q) cur = nst;
    else if (wb_v_q && wb_sym_q == s1_sym_q) cur = wb_st_q;
  end

  assign sqs = (2*SampW)'(s2_samp_q) * (2*SampW)'(s2_samp_q);
  assign sqo = (2*SampW)'(old) * (2*SampW)'(old);
  assign pn = s2_fs_q ? (PosW+2)'(s2_st_q.pos) - (PosW+2)'(s2_fq_q)
                      : (PosW+2)'(s2_st_q.pos) + (PosW+2)'(s2_fq_q);

  always_comb begin
    nst = s2_st_q;
    if (s2_op_q == OpFill) begin
      if (pn > $signed({2'b00, PosMax})) nst.pos = $signed(PosMax);
      else if (pn < -$signed({2'b00, PosMax})) nst.pos = -$signed(PosMax);
      else nst.pos = pn[PosW-1:0];
    end else begin
      nst.head = s2_st_q.head + 1'b1;
      if (s2_st_q.cnt < CntW'(WindowLen)) begin
        nst.sum = s2_st_q.sum + SumW'(s2_samp_q);
        nst.sq = s2_st_q.sq + SqW'(sqs);
        nst.cnt = s2_st_q.cnt + 1'b1;
      end else begin
        nst.sum = s2_st_q.sum + SumW'(s2_samp_q) - SumW'(old);
        nst.sq = s2_st_q.sq + SqW'(sqs) - SqW'(sqo);
      end
    end
  end

  assign ev_v = s2_v_q && s2_op_q == OpTick && nst.cnt == CntW'(WindowLen);

  rzs_eval u_eval (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .in_valid_i(wb_ev_q),
    .sum_i(wb_st_q.sum), .sq_i(wb_st_q.sq), .samp_i(wb_samp_q), .pos_i(wb_st_q.pos),
    .bid_i(wb_bid_q), .ask_i(wb_ask_q),
    .entry_thr_i(entry_q), .exit_thr_i(exit_q),
    .out_valid_o(out_valid_o), .order_side_o(order_side_o),
    .order_price_o(order_price_o), .order_quantity_o(order_quantity_o)
  );

`ifndef SYNTHESIS
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o) else $error("input stalled without output pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result lost");
`endif
endmodule

[design/rzs_state_mem.sv]
// Per-symbol state memory and price ring with registered synchronous reads.
module rzs_state_mem (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic [rzs_pkg::SymW-1:0] rd_sym_i,
  output rzs_pkg::sym_state_t rd_state_o,
  input  logic wr_en_i,
  input  logic [rzs_pkg::SymW-1:0] wr_sym_i,
  input  rzs_pkg::sym_state_t wr_state_i,
  input  logic [rzs_pkg::RingAw-1:0] ring_addr_i,
  input  logic ring_we_i,
  input  logic [rzs_pkg::SampW-1:0] ring_wdata_i,
  output logic [rzs_pkg::SampW-1:0] ring_rdata_o
);
  import rzs_pkg::*;
  sym_state_t st_mem [NumSymbols];
  logic [SampW-1:0] ring_mem [NumSymbols*WindowLen];
  logic [NumSymbols-1:0] vld_q;
  logic [SymW-1:0] rsym_q;
  sym_state_t rdat_q;
  logic [SampW-1:0] ring_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (wr_en_i) st_mem[wr_sym_i] <= wr_state_i;
      rdat_q <= st_mem[rd_sym_i];
      if (ring_we_i) ring_mem[ring_addr_i] <= ring_wdata_i;
      ring_q <= ring_mem[ring_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rsym_q <= '0;
    end else if (en_i) begin
      if (wr_en_i) vld_q[wr_sym_i] <= 1'b1;
      rsym_q <= rd_sym_i;
    end
  end

  assign rd_state_o = vld_q[rsym_q] ? rdat_q : '0;
  assign ring_rdata_o = ring_q;
endmodule

[design/rzs_eval.sv]
// Pipelined variance and deviation test that builds the order item.
module rzs_eval (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic in_valid_i,
  input  logic [rzs_pkg::SumW-1:0] sum_i,
  input  logic [rzs_pkg::SqW-1:0] sq_i,
  input  logic [rzs_pkg::SampW-1:0] samp_i,
  input  logic signed [rzs_pkg::PosW-1:0] pos_i,
  input  logic [rzs_pkg::PriceBits-1:0] bid_i,
  input  logic [rzs_pkg::PriceBits-1:0] ask_i,
  input  logic [7:0] entry_thr_i,
  input  logic [7:0] exit_thr_i,
  output logic out_valid_o,
  output logic order_side_o,
  output logic [23:0] order_price_o,
  output logic [30:0] order_quantity_o
);
  import rzs_pkg::*;
  localparam int VarW = SqW + HeadW + 1;
  localparam int LhsW = 2 * SumW + 3;
  localparam int PrdW = VarW + 8;

  logic v1_q, v2_q;
  logic [VarW-1:0] wq1_q, ss1_q, var2_q;
  logic [SumW-1:0] mag1_q;
  logic above1_q, above2_q;
  logic signed [PosW-1:0] pos1_q, pos2_q;
  logic [PriceBits-1:0] bid1_q, ask1_q, bid2_q, ask2_q;
  logic [LhsW-1:0] lhs2_q;
  logic [SumW-1:0] ws;
  logic [VarW-1:0] var_d;
  logic [PrdW-1:0] rhs;
  logic [7:0] thr;
  logic hit, side;
  logic [31:0] apos;

  assign ws = SumW'(samp_i) << HeadW;
  assign var_d = wq1_q - ss1_q;
  assign thr = (pos2_q == 0) ? entry_thr_i : exit_thr_i;
  assign rhs = PrdW'(var2_q) * PrdW'(thr);
  assign apos = pos2_q[PosW-1] ? 32'(-pos2_q) : 32'(pos2_q);

  always_comb begin
    if (pos2_q == 0) begin
      hit = PrdW'(lhs2_q) >= rhs;
      side = above2_q;
    end else begin
      hit = PrdW'(lhs2_q) <= rhs;
      side = !pos2_q[PosW-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q && (var_d != '0);
      out_valid_o <= v2_q && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wq1_q <= VarW'(sq_i) << HeadW;
      ss1_q <= VarW'(sum_i) * VarW'(sum_i);
      above1_q <= ws > sum_i;
      mag1_q <= (ws > sum_i) ? ws - sum_i : sum_i - ws;
      pos1_q <= pos_i;
      bid1_q <= bid_i;
      ask1_q <= ask_i;
      var2_q <= var_d;
      lhs2_q <= (LhsW'(mag1_q) * LhsW'(mag1_q)) << 2;
      above2_q <= above1_q;
      pos2_q <= pos1_q;
      bid2_q <= bid1_q;
      ask2_q <= ask1_q;
      order_side_o <= side;
      order_price_o <= 24'(side ? bid2_q : ask2_q);
      order_quantity_o <= (pos2_q == 0) ? 31'd1 : apos[30:0];
    end
  end
endmodule
